// ===== hdl/gccu_pkg.sv =====
`default_nettype none

package gccu_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int HEIGHT_W = 16;
    localparam int ADDR_W   = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 11;
    localparam int COORD_W  = 11;
    localparam int SUM_W    = HEIGHT_W + 5;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(3);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    // register indexes on the configuration port
    localparam logic REG_POINTS_PER_SIDE = 1'b0;

    typedef logic signed [HEIGHT_W-1:0] height_t;

    // one finished 2x2 cell, handed from the front to the back
    typedef struct packed {
        height_t              a;
        height_t              b;
        height_t              c;
        height_t              d;
        logic [COORD_W-1:0]   row0;
        logic [COORD_W-1:0]   col0;
        logic                 fin;
    } cell_t;

    // (9*near + 3*s1 + 3*s2 + far + 8) >> 4, floor on the signed sum
    function automatic height_t blend(height_t near, height_t s1, height_t s2, height_t far);
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(near) * SUM_W'(9)
            + SUM_W'(s1) * SUM_W'(3)
            + SUM_W'(s2) * SUM_W'(3)
            + SUM_W'(far)
            + SUM_W'(8);
        return sum[HEIGHT_W+3:4];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gccu_ram.sv =====
`default_nettype none

module gccu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and a write at one address return the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/gccu_front.sv =====
`default_nettype none

module gccu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [gccu_pkg::SIDE_W-1:0]   side,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire gccu_pkg::height_t             height,
    input  wire logic                          grid_start,
    output      logic                          cell_valid,
    input  wire logic                          cell_ready,
    output      gccu_pkg::cell_t               quad
);

    localparam int AW = gccu_pkg::ADDR_W;
    localparam int SW = gccu_pkg::SIDE_W;
    localparam int CW = gccu_pkg::COORD_W;

    logic [AW-1:0]        row_reg, row_next;
    logic [AW-1:0]        col_reg, col_next;
    logic [SW-1:0]        n_eff;
    logic [AW-1:0]        row_eff, col_eff;
    logic                 row_last, col_last;
    logic                 accept;

    logic                 s1_valid_reg;
    logic                 s1_cell_reg;
    logic                 s1_fin_reg;
    gccu_pkg::height_t    s1_d_reg;
    logic [CW-1:0]        s1_row0_reg;
    logic [CW-1:0]        s1_col0_reg;
    logic                 s1_go;

    gccu_pkg::height_t    left_reg;
    gccu_pkg::height_t    upper_left_reg;
    logic [gccu_pkg::HEIGHT_W-1:0] above;

    always_comb
    begin
        if (side < gccu_pkg::SIDE_MIN)
        begin
            n_eff = gccu_pkg::SIDE_MIN;
        end
        else if (side > gccu_pkg::SIDE_MAX)
        begin
            n_eff = gccu_pkg::SIDE_MAX;
        end
        else
        begin
            n_eff = side;
        end
    end

    always_comb
    begin
        row_eff = (grid_start || SW'(row_reg) >= n_eff) ? '0 : row_reg;
        col_eff = (grid_start || SW'(col_reg) >= n_eff) ? '0 : col_reg;
        row_last = (SW'(row_eff) + SW'(1)) >= n_eff;
        col_last = (SW'(col_eff) + SW'(1)) >= n_eff;
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_eff + AW'(1);
        end
        else
        begin
            col_next = col_eff + AW'(1);
            row_next = row_eff;
        end
    end

    assign s1_go    = s1_valid_reg && (!s1_cell_reg || cell_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    // the line store is read and written at the same column in one cycle
    gccu_ram #(
        .WIDTH (gccu_pkg::HEIGHT_W),
        .DEPTH (gccu_pkg::MAX_SIDE)
    ) u_line (
        .clk   (clk),
        .we    (accept),
        .waddr (col_eff),
        .wdata (height),
        .re    (accept),
        .raddr (col_eff),
        .rdata (above)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                left_reg       <= s1_d_reg;
                upper_left_reg <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_d_reg    <= height;
            s1_cell_reg <= (row_eff != '0) && (col_eff != '0);
            s1_fin_reg  <= row_last && col_last;
            s1_row0_reg <= CW'({row_eff - AW'(1), 1'b0});
            s1_col0_reg <= CW'({col_eff - AW'(1), 1'b0});
        end
    end

    assign cell_valid = s1_valid_reg && s1_cell_reg;

    always_comb
    begin
        quad.a    = upper_left_reg;
        quad.b    = above;
        quad.c    = left_reg;
        quad.d    = s1_d_reg;
        quad.row0 = s1_row0_reg;
        quad.col0 = s1_col0_reg;
        quad.fin  = s1_fin_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/gccu_queue.sv =====
`default_nettype none

module gccu_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire gccu_pkg::cell_t  push_data,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      gccu_pkg::cell_t  pop_data
);

    gccu_pkg::cell_t entry_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      count_reg;
    logic            push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gccu_back.sv =====
`default_nettype none

module gccu_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cell_valid,
    output      logic                          cell_ready,
    input  wire gccu_pkg::cell_t               quad,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      gccu_pkg::height_t             value,
    output      logic [gccu_pkg::COORD_W-1:0]  out_row,
    output      logic [gccu_pkg::COORD_W-1:0]  out_col,
    output      logic                          last
);

    localparam int CW = gccu_pkg::COORD_W;

    logic [1:0]         k_reg;
    logic               out_valid_reg;
    gccu_pkg::height_t  value_reg;
    logic [CW-1:0]      row_reg;
    logic [CW-1:0]      col_reg;
    logic               last_reg;
    logic               load;
    gccu_pkg::height_t  near, s1, s2, far;

    assign load       = cell_valid && (!out_valid_reg || out_ready);
    assign cell_ready = load && (k_reg == 2'd3);

    // the corner nearest to each of the four refined points
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                near = quad.a; s1 = quad.b; s2 = quad.c; far = quad.d;
            end
            2'd1:
            begin
                near = quad.b; s1 = quad.a; s2 = quad.d; far = quad.c;
            end
            2'd2:
            begin
                near = quad.c; s1 = quad.a; s2 = quad.d; far = quad.b;
            end
            2'd3:
            begin
                near = quad.d; s1 = quad.b; s2 = quad.c; far = quad.a;
            end
            default:
            begin
                near = quad.a; s1 = quad.b; s2 = quad.c; far = quad.d;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                k_reg         <= k_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= gccu_pkg::blend(near, s1, s2, far);
            row_reg   <= quad.row0 + CW'(k_reg[1]);
            col_reg   <= quad.col0 + CW'(k_reg[0]);
            last_reg  <= quad.fin && (k_reg == 2'd3);
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== hdl/grid_corner_cut_upsampler_core.sv =====
// Refines a square height grid by corner cutting.
// Input stream (s_*): one signed Q8.8 height per item in row-major order,
// s_tuser high on the first sample of a grid. Output stream (m_*): refined
// heights with their row and column in the refined grid, m_tlast on the very
// last value. Each sample outside the first row and column closes a 2x2 cell
// and gives four values; samples of the first row or column give none.
// The side length is set through the APB register at address 0 (reset 3,
// used clamped to 2..1024); write it only while the block is idle.
// A cell's first value passes the front-end sample register, the cell queue
// and the back-end output register. The output register delivers one value per
// cycle while m_tready is high; samples that close no cell are taken one per
// cycle. Work is bounded by the single output port of the back end.
// A two-entry cell queue separates the sample front end from the back end,
// so samples keep flowing while values wait. When m_tready is low the output
// holds, the queue fills and then s_tready drops.
// Reset clears counters, neighbor samples and all valid flags; the line store
// is not cleared and is valid once the first row of a grid has been written.
`default_nettype none

module grid_corner_cut_upsampler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // height[15:0]
    input  wire logic        s_tuser,   // grid_start
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,   // value[15:0], out_row[26:16], out_col[37:27], zero
    output      logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int SW = gccu_pkg::SIDE_W;
    localparam int CW = gccu_pkg::COORD_W;

    logic [SW-1:0]     side_reg;
    logic              cfg_write;

    logic              fq_valid, fq_ready;
    gccu_pkg::cell_t   fq_cell;
    logic              qb_valid, qb_ready;
    gccu_pkg::cell_t   qb_cell;

    gccu_pkg::height_t value;
    logic [CW-1:0]     out_row, out_col;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= gccu_pkg::SIDE_RESET;
        end
        else if (cfg_write && paddr[2] == gccu_pkg::REG_POINTS_PER_SIDE)
        begin
            side_reg <= pwdata[SW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == gccu_pkg::REG_POINTS_PER_SIDE)
        begin
            prdata = 32'(side_reg);
        end
    end

    gccu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .height     (s_tdata),
        .grid_start (s_tuser),
        .cell_valid (fq_valid),
        .cell_ready (fq_ready),
        .quad       (fq_cell)
    );

    gccu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cell),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cell)
    );

    gccu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (qb_valid),
        .cell_ready (qb_ready),
        .quad       (qb_cell),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .value      (value),
        .out_row    (out_row),
        .out_col    (out_col),
        .last       (m_tlast)
    );

    assign m_tdata = {2'b00, out_col, out_row, value};

endmodule

`default_nettype wire

// ===== hdl/gccu_checker.sv =====
`default_nettype none

module gccu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // the final value sits on the diagonal at an odd row
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[26:16] == m_tdata[37:27] && m_tdata[16])
        else $error("last flag on a value off the final corner");

    // an even column value is followed at once by its right neighbor
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tdata[27] |=>
            m_tvalid && m_tdata[26:16] == $past(m_tdata[26:16])
            && m_tdata[37:27] == 11'($past(m_tdata[37:27]) + 11'd1))
        else $error("cell values not delivered back to back");

    // a value carries no padding bits
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:38] == 2'b00)
        else $error("padding bits set on output item");

endmodule

bind grid_corner_cut_upsampler_core gccu_checker u_gccu_checker (.*);

`default_nettype wire
